// File: rtl/core/ntt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_pkg
// Shared widths, register indexes, pitch table and prescaler step table for
// the note to tone timer setting block.
// ----------------------------------------------------------------------------
package ntt_pkg;

	localparam int unsigned WordW    = 16;
	localparam int unsigned IdxW     = 4;
	localparam int unsigned OctW     = 3;
	localparam int unsigned UnitsW   = 9;
	localparam int unsigned ClockW   = 24;
	localparam int unsigned MinNoteW = 10;
	localparam int unsigned ToneW    = 13;
	localparam int unsigned SelW     = 3;
	localparam int unsigned CmpW     = 8;
	localparam int unsigned ToneMsW  = 19;
	localparam int unsigned PauseW   = 9;
	localparam int unsigned StepCntW = 3;
	localparam int unsigned ShiftW   = 4;

	// configuration register indexes
	localparam int unsigned CfgIndexW = 1;
	localparam logic [CfgIndexW-1:0] RegClockHalfHz = 1'b0;
	localparam logic [CfgIndexW-1:0] RegMinNoteMs   = 1'b1;

	localparam logic [ClockW-1:0]   ClockHalfHzReset = 24'd8000000;
	localparam logic [MinNoteW-1:0] MinNoteMsReset   = 10'd100;

	// largest count the 8-bit compare register can express
	localparam int unsigned CountLimit = 256;
	localparam int unsigned NumSteps   = 6;
	localparam logic [OctW-1:0] TopOctave = 3'd7;
	localparam logic [CmpW-1:0] CmpSaturated = 8'hFF;
	localparam logic [SelW-1:0] SelRest = 3'd0;

	typedef struct packed {
		logic                 end_of_melody;
		logic                 is_rest;
		logic [ToneW-1:0]     tone_hz;
		logic [ToneMsW-1:0]   tone_ms;
	} ntt_meta_t;

	// fifth-octave pitches in Hz, index 0 and anything past the table is a rest
	function automatic logic [ToneW-1:0] pitch_lookup(input logic [IdxW-1:0] idx);
		logic [ToneW-1:0] hz;
		case (idx)
			4'd1:    hz = 13'd4186;
			4'd2:    hz = 13'd4435;
			4'd3:    hz = 13'd4698;
			4'd4:    hz = 13'd4978;
			4'd5:    hz = 13'd5274;
			4'd6:    hz = 13'd5588;
			4'd7:    hz = 13'd5920;
			4'd8:    hz = 13'd6272;
			4'd9:    hz = 13'd6645;
			4'd10:   hz = 13'd7040;
			4'd11:   hz = 13'd7459;
			4'd12:   hz = 13'd7902;
			default: hz = '0;
		endcase
		return hz;
	endfunction

	// total right shift of the count after n prescaler steps
	// (dividers 1, 8, 32, 64, 128, 256, 1024)
	function automatic logic [ShiftW-1:0] cum_shift(input logic [StepCntW-1:0] n);
		logic [ShiftW-1:0] sh;
		case (n)
			3'd0:    sh = 4'd0;
			3'd1:    sh = 4'd3;
			3'd2:    sh = 4'd5;
			3'd3:    sh = 4'd6;
			3'd4:    sh = 4'd7;
			3'd5:    sh = 4'd8;
			default: sh = 4'd10;
		endcase
		return sh;
	endfunction

endpackage

// File: rtl/core/note_to_tone_timer_setting.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_to_tone_timer_setting
// Turns packed melody note words into tone timer prescaler and compare
// settings, plus tone and pause lengths in milliseconds.
// ----------------------------------------------------------------------------
// One note word is taken every clock cycle while the output side is not
// stalled, and each gives exactly one result item, in order, after one
// decode stage, 24 stages of the restoring divider that forms the count
// (one quotient bit per stage) and one stage for the prescaler cascade and
// output register. Back-pressure stalls only the full stages nearest the
// output, so bubbles in the pipe are squeezed out. The two configuration
// registers are read as items pass through, so write them only while no
// item is in flight.
// ----------------------------------------------------------------------------
module note_to_tone_timer_setting (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ntt_pkg::CfgIndexW-1:0]       cfg_index,
	input  logic [ntt_pkg::ClockW-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ntt_pkg::WordW-1:0]           note_word,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                end_of_melody,
	output logic                                is_rest,
	output logic [ntt_pkg::ToneW-1:0]           tone_hz,
	output logic [ntt_pkg::SelW-1:0]            prescale_select,
	output logic [ntt_pkg::CmpW-1:0]            compare_value,
	output logic                                range_error,
	output logic [ntt_pkg::ToneMsW-1:0]         tone_ms,
	output logic [ntt_pkg::PauseW-1:0]          pause_ms
);

	logic [ntt_pkg::ClockW-1:0]   clock_half_hz_q;
	logic [ntt_pkg::MinNoteW-1:0] min_note_ms_q;

	logic                         dec_valid;
	logic                         dec_ready;
	logic [ntt_pkg::ClockW-1:0]   dec_num;
	logic [ntt_pkg::ToneW-1:0]    dec_div;
	ntt_pkg::ntt_meta_t           dec_meta;

	logic                         div_valid;
	logic                         div_ready;
	logic [ntt_pkg::ClockW-1:0]   div_quo;
	ntt_pkg::ntt_meta_t           div_meta;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_half_hz_q <= ntt_pkg::ClockHalfHzReset;
			min_note_ms_q   <= ntt_pkg::MinNoteMsReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ntt_pkg::RegClockHalfHz: clock_half_hz_q <= cfg_data;
				ntt_pkg::RegMinNoteMs:   min_note_ms_q   <= cfg_data[ntt_pkg::MinNoteW-1:0];
				default: ;
			endcase
		end
	end

	ntt_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.note_word     (note_word),
		.clock_half_hz (clock_half_hz_q),
		.min_note_ms   (min_note_ms_q),
		.out_valid     (dec_valid),
		.out_ready     (dec_ready),
		.out_num       (dec_num),
		.out_div       (dec_div),
		.out_meta      (dec_meta)
	);

	ntt_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dec_valid),
		.in_ready  (dec_ready),
		.in_num    (dec_num),
		.in_div    (dec_div),
		.in_meta   (dec_meta),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_quo   (div_quo),
		.out_meta  (div_meta)
	);

	ntt_prescale u_prescale (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (div_valid),
		.in_ready        (div_ready),
		.in_count        (div_quo),
		.in_meta         (div_meta),
		.min_note_ms     (min_note_ms_q),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.end_of_melody   (end_of_melody),
		.is_rest         (is_rest),
		.tone_hz         (tone_hz),
		.prescale_select (prescale_select),
		.compare_value   (compare_value),
		.range_error     (range_error),
		.tone_ms         (tone_ms),
		.pause_ms        (pause_ms)
	);

	// end of melody item carries nothing else
	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && end_of_melody) |-> (!is_rest && (tone_hz == '0)
		&& (prescale_select == ntt_pkg::SelRest) && (compare_value == '0)
		&& !range_error && (tone_ms == '0) && (pause_ms == '0)))
		else $error("end of melody item has non-zero fields");

	// a rest never selects a timer clock
	a_rest_no_timer: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_rest) |-> ((prescale_select == ntt_pkg::SelRest)
		&& (tone_hz == '0) && !range_error && !end_of_melody))
		else $error("rest item selects a timer clock");

	// a sounding note always has a real clock select and a tone
	a_tone_has_sel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_rest && !end_of_melody) |->
		((prescale_select != ntt_pkg::SelRest) && (tone_hz != '0)))
		else $error("sounding note without clock select");

	// saturation only at the largest divider
	a_range_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && range_error) |->
		((prescale_select == 3'd7) && (compare_value == ntt_pkg::CmpSaturated)))
		else $error("range error without saturated setting");

endmodule

// File: rtl/core/ntt_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_decode
// First pipeline stage: unpacks the note word, looks up and octave-shifts the
// pitch, works out the tone length and sets up the count division.
// ----------------------------------------------------------------------------
module ntt_decode (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ntt_pkg::WordW-1:0]         note_word,
	input  logic [ntt_pkg::ClockW-1:0]        clock_half_hz,
	input  logic [ntt_pkg::MinNoteW-1:0]      min_note_ms,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ntt_pkg::ClockW-1:0]        out_num,
	output logic [ntt_pkg::ToneW-1:0]         out_div,
	output ntt_pkg::ntt_meta_t                out_meta
);

	logic [ntt_pkg::IdxW-1:0]    idx;
	logic [ntt_pkg::OctW-1:0]    oct;
	logic [ntt_pkg::UnitsW-1:0]  units;
	logic                        is_end;
	logic                        is_rest;
	logic [ntt_pkg::ToneW-1:0]   tone;
	logic [ntt_pkg::ToneMsW-1:0] tone_ms;
	ntt_pkg::ntt_meta_t          meta;

	logic                        vld_s1;
	logic [ntt_pkg::ClockW-1:0]  num_s1;
	logic [ntt_pkg::ToneW-1:0]   div_s1;
	ntt_pkg::ntt_meta_t          meta_s1;

	assign idx   = note_word[3:0];
	assign oct   = note_word[6:4];
	assign units = note_word[15:7];

	always_comb begin
		is_end  = (note_word == '0);
		is_rest = !is_end && ((idx == '0) || (idx > 4'd12));
		if (is_end || is_rest) begin
			tone = '0;
		end else begin
			tone = ntt_pkg::pitch_lookup(idx) >> (ntt_pkg::TopOctave - oct);
		end
		if (is_end) begin
			tone_ms = '0;
		end else begin
			tone_ms = ntt_pkg::ToneMsW'({10'd0, units} * {9'd0, min_note_ms});
		end
		meta.end_of_melody = is_end;
		meta.is_rest       = is_rest;
		meta.tone_hz       = tone;
		meta.tone_ms       = tone_ms;
	end

	assign in_ready = !vld_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			num_s1  <= clock_half_hz;
			div_s1  <= tone;
			meta_s1 <= meta;
		end
	end

	assign out_valid = vld_s1;
	assign out_num   = num_s1;
	assign out_div   = div_s1;
	assign out_meta  = meta_s1;

endmodule

// File: rtl/core/ntt_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_divider
// Pipelined restoring divider, one quotient bit per stage, with the note
// fields carried alongside. Each stage stalls only when it is full and the
// stage after it cannot take its item.
// ----------------------------------------------------------------------------
module ntt_divider (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ntt_pkg::ClockW-1:0]   in_num,
	input  logic [ntt_pkg::ToneW-1:0]    in_div,
	input  ntt_pkg::ntt_meta_t           in_meta,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ntt_pkg::ClockW-1:0]   out_quo,
	output ntt_pkg::ntt_meta_t           out_meta
);

	localparam int unsigned NumW = ntt_pkg::ClockW;
	localparam int unsigned DivW = ntt_pkg::ToneW;

	logic                vld_s  [1:NumW];
	logic                rdy_s  [1:NumW];
	logic [NumW-1:0]     num_s  [1:NumW];
	logic [NumW-1:0]     quo_s  [1:NumW];
	logic [DivW-1:0]     rem_s  [1:NumW];
	logic [DivW-1:0]     div_s  [1:NumW];
	ntt_pkg::ntt_meta_t  meta_s [1:NumW];

	for (genvar k = 1; k <= NumW; k++) begin : g_stage
		logic               p_vld;
		logic [NumW-1:0]    p_num;
		logic [NumW-1:0]    p_quo;
		logic [DivW-1:0]    p_rem;
		logic [DivW-1:0]    p_div;
		ntt_pkg::ntt_meta_t p_meta;
		logic               nxt_rdy;
		logic [DivW:0]      trial;
		logic [DivW:0]      diff;
		logic               ge;

		if (k == 1) begin : g_first
			assign p_vld  = in_valid;
			assign p_num  = in_num;
			assign p_quo  = '0;
			assign p_rem  = '0;
			assign p_div  = in_div;
			assign p_meta = in_meta;
		end else begin : g_next
			assign p_vld  = vld_s[k-1];
			assign p_num  = num_s[k-1];
			assign p_quo  = quo_s[k-1];
			assign p_rem  = rem_s[k-1];
			assign p_div  = div_s[k-1];
			assign p_meta = meta_s[k-1];
		end

		if (k == NumW) begin : g_last
			assign nxt_rdy = out_ready;
		end else begin : g_mid
			assign nxt_rdy = rdy_s[k+1];
		end

		assign rdy_s[k] = !vld_s[k] || nxt_rdy;

		// bring down the next dividend bit and try the subtract
		assign trial = {p_rem, p_num[NumW-1]};
		assign ge    = (trial >= {1'b0, p_div});
		assign diff  = trial - {1'b0, p_div};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy_s[k]) begin
				vld_s[k] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy_s[k] && p_vld) begin
				rem_s[k]  <= ge ? diff[DivW-1:0] : trial[DivW-1:0];
				num_s[k]  <= {p_num[NumW-2:0], 1'b0};
				quo_s[k]  <= {p_quo[NumW-2:0], ge};
				div_s[k]  <= p_div;
				meta_s[k] <= p_meta;
			end
		end
	end

	assign in_ready  = rdy_s[1];
	assign out_valid = vld_s[NumW];
	assign out_quo   = quo_s[NumW];
	assign out_meta  = meta_s[NumW];

	// remainder stays below a non-zero divisor at the end of the pipe
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[NumW] && (div_s[NumW] != '0)) |-> (rem_s[NumW] < div_s[NumW]))
		else $error("divider remainder not below divisor");

	// a stalled last stage keeps its quotient
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[NumW] && !out_ready) |=> (vld_s[NumW] && $stable(quo_s[NumW])))
		else $error("divider output changed while stalled");

endmodule

// File: rtl/core/ntt_prescale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_prescale
// Last pipeline stage: runs the prescaler cascade on the divided count,
// forms the compare value and holds the result item in the output register.
// ----------------------------------------------------------------------------
module ntt_prescale (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ntt_pkg::ClockW-1:0]    in_count,
	input  ntt_pkg::ntt_meta_t            in_meta,
	input  logic [ntt_pkg::MinNoteW-1:0]  min_note_ms,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          end_of_melody,
	output logic                          is_rest,
	output logic [ntt_pkg::ToneW-1:0]     tone_hz,
	output logic [ntt_pkg::SelW-1:0]      prescale_select,
	output logic [ntt_pkg::CmpW-1:0]      compare_value,
	output logic                          range_error,
	output logic [ntt_pkg::ToneMsW-1:0]   tone_ms,
	output logic [ntt_pkg::PauseW-1:0]    pause_ms
);

	localparam int unsigned CntW = ntt_pkg::ClockW;

	logic [ntt_pkg::NumSteps:0]       pass;
	logic [ntt_pkg::StepCntW-1:0]     steps;
	logic [CntW-1:0]                  shifted;
	logic [ntt_pkg::SelW-1:0]         sel;
	logic [ntt_pkg::CmpW-1:0]         cmp;
	logic                             err;
	logic [ntt_pkg::PauseW-1:0]       pause;

	logic                             vld_s3;
	logic                             end_s3;
	logic                             rest_s3;
	logic [ntt_pkg::ToneW-1:0]        tone_s3;
	logic [ntt_pkg::SelW-1:0]         sel_s3;
	logic [ntt_pkg::CmpW-1:0]         cmp_s3;
	logic                             err_s3;
	logic [ntt_pkg::ToneMsW-1:0]      tone_ms_s3;
	logic [ntt_pkg::PauseW-1:0]       pause_s3;

	always_comb begin
		// count >> s exceeds the limit exactly when count >= (limit + 1) << s
		for (int k = 0; k <= ntt_pkg::NumSteps; k++) begin
			pass[k] = (in_count >= (CntW'(ntt_pkg::CountLimit + 1)
				<< ntt_pkg::cum_shift(ntt_pkg::StepCntW'(k))));
		end
		// thresholds rise, so the passed steps form a thermometer code
		steps = '0;
		for (int k = 0; k < ntt_pkg::NumSteps; k++) begin
			if (pass[k]) begin
				steps = ntt_pkg::StepCntW'(k + 1);
			end
		end
		shifted = in_count >> ntt_pkg::cum_shift(steps);
		if (in_meta.end_of_melody || in_meta.is_rest) begin
			sel = ntt_pkg::SelRest;
			cmp = '0;
			err = 1'b0;
		end else begin
			sel = ntt_pkg::SelW'(steps + 3'd1);
			err = pass[ntt_pkg::NumSteps];
			cmp = err ? ntt_pkg::CmpSaturated : ntt_pkg::CmpW'(shifted - 1'b1);
		end
		pause = in_meta.end_of_melody ? '0 : ntt_pkg::PauseW'(min_note_ms >> 1);
	end

	assign in_ready = !vld_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (in_ready) begin
			vld_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			end_s3     <= in_meta.end_of_melody;
			rest_s3    <= in_meta.is_rest;
			tone_s3    <= in_meta.tone_hz;
			sel_s3     <= sel;
			cmp_s3     <= cmp;
			err_s3     <= err;
			tone_ms_s3 <= in_meta.tone_ms;
			pause_s3   <= pause;
		end
	end

	assign out_valid       = vld_s3;
	assign end_of_melody   = end_s3;
	assign is_rest         = rest_s3;
	assign tone_hz         = tone_s3;
	assign prescale_select = sel_s3;
	assign compare_value   = cmp_s3;
	assign range_error     = err_s3;
	assign tone_ms         = tone_ms_s3;
	assign pause_ms        = pause_s3;

endmodule

// File: bench/tb_note_to_tone_timer_setting.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_note_to_tone_timer_setting
// Drives note words through the note to tone timer setting block under random
// handshake gaps and back-pressure. Each result is checked field by field
// against a behavioural predictor of the pitch table, octave shift, prescaler
// cascade and length arithmetic, over several timer clock and note length
// settings.
// ----------------------------------------------------------------------------
module tb_note_to_tone_timer_setting;
	import ntt_pkg::*;

	localparam int unsigned StallMax      = 12;
	localparam int unsigned WatchdogLimit = 2000;
	localparam int unsigned DrainCycles   = 40;
	localparam int unsigned RandomPhases  = 6;
	localparam int unsigned NotesPerPhase = 240;
	localparam int unsigned SelMax        = 7;

	// fifth-octave pitch in Hz per pitch index, zero where the index is a rest
	localparam int unsigned FifthOctaveHz [16] = '{0, 4186, 4435, 4698, 4978, 5274, 5588,
		5920, 6272, 6645, 7040, 7459, 7902, 0, 0, 0};
	// log2 of the timer divider for select 1..7
	localparam int unsigned DividerLog2 [7] = '{0, 3, 5, 6, 7, 8, 10};

	typedef struct packed {
		logic               end_of_melody;
		logic               is_rest;
		logic [ToneW-1:0]   tone_hz;
		logic [SelW-1:0]    prescale_select;
		logic [CmpW-1:0]    compare_value;
		logic               range_error;
		logic [ToneMsW-1:0] tone_ms;
		logic [PauseW-1:0]  pause_ms;
	} tone_setting_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CfgIndexW-1:0] cfg_index = '0;
	logic [ClockW-1:0]    cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic [WordW-1:0]     note_word = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 end_of_melody;
	logic                 is_rest;
	logic [ToneW-1:0]     tone_hz;
	logic [SelW-1:0]      prescale_select;
	logic [CmpW-1:0]      compare_value;
	logic                 range_error;
	logic [ToneMsW-1:0]   tone_ms;
	logic [PauseW-1:0]    pause_ms;

	logic [ClockW-1:0]   clock_half_hz_set = ClockHalfHzReset;
	logic [MinNoteW-1:0] min_note_ms_set   = MinNoteMsReset;
	tone_setting_t       expected_settings [$];
	int unsigned         error_count          = 0;
	bit                  sender_gaps          = 1'b1;
	bit                  receiver_stalls      = 1'b1;
	int unsigned         receiver_hold_cycles = 0;
	int unsigned         idle_cycles          = 0;

	note_to_tone_timer_setting i_dut (.*);

	always #5 clk = ~clk;

	function automatic logic [WordW-1:0] pack_note(input int unsigned units,
			input int unsigned octave, input int unsigned idx);
		return {UnitsW'(units), OctW'(octave), IdxW'(idx)};
	endfunction

	// mostly pitched notes, the rest fully random words
	function automatic logic [WordW-1:0] random_note();
		if ($urandom_range(0, 3) == 0)
			return WordW'($urandom);
		return pack_note($urandom_range(0, 511), $urandom_range(0, 7), $urandom_range(1, 12));
	endfunction

	function automatic tone_setting_t predict_setting(input logic [WordW-1:0] word);
		tone_setting_t s;
		logic [IdxW-1:0] idx;
		logic [OctW-1:0] octave;
		int unsigned     units;
		int unsigned     length;
		int unsigned     pitch;
		int unsigned     count;
		int unsigned     scaled;
		int unsigned     sel;
		s      = '0;
		idx    = word[IdxW-1:0];
		octave = word[IdxW+OctW-1:IdxW];
		units  = 32'(word[WordW-1:IdxW+OctW]);
		if (word == '0) begin
			s.end_of_melody = 1'b1;
			return s;
		end
		length     = units * 32'(min_note_ms_set);
		s.tone_ms  = ToneMsW'(length);
		s.pause_ms = PauseW'(min_note_ms_set >> 1);
		if (FifthOctaveHz[idx] == 0) begin
			s.is_rest = 1'b1;
			return s;
		end
		pitch     = FifthOctaveHz[idx] >> (TopOctave - octave);
		s.tone_hz = ToneW'(pitch);
		count     = 32'(clock_half_hz_set) / pitch;
		// step up the divider until the count fits the compare register
		sel = 1;
		while (sel < SelMax && (count >> DividerLog2[sel-1]) > CountLimit)
			sel++;
		scaled            = count >> DividerLog2[sel-1];
		s.prescale_select = SelW'(sel);
		if (scaled > CountLimit) begin
			s.range_error   = 1'b1;
			s.compare_value = CmpSaturated;
		end else begin
			// a zero count wraps to 255
			s.compare_value = CmpW'(scaled - 1);
		end
		return s;
	endfunction

	function automatic void check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			error_count++;
			$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
		end
	endfunction

	task automatic send_note(input logic [WordW-1:0] word);
		int unsigned gap;
		gap = sender_gaps ? $urandom_range(0, StallMax) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		note_word <= word;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_settings.push_back(predict_setting(word));
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (expected_settings.size() != 0) @(posedge clk);
	endtask

	task automatic write_timer_config(input logic [ClockW-1:0] clock_hz,
			input logic [MinNoteW-1:0] note_ms);
		wait_for_results();
		cfg_we    <= 1'b1;
		cfg_index <= RegClockHalfHz;
		cfg_data  <= clock_hz;
		@(posedge clk);
		cfg_index <= RegMinNoteMs;
		cfg_data  <= ClockW'(note_ms);
		@(posedge clk);
		cfg_we            <= 1'b0;
		clock_half_hz_set = clock_hz;
		min_note_ms_set   = note_ms;
		@(posedge clk);
	endtask

	// end of melody, rests, every pitch and octave, length extremes
	task automatic test_directed_notes();
		send_note(16'h0000);
		send_note(pack_note(511, 7, 0));
		send_note(pack_note(1, 0, 13));
		send_note(pack_note(3, 5, 14));
		send_note(16'hFFFF);
		for (int unsigned idx = 1; idx <= 12; idx++)
			send_note(pack_note($urandom_range(1, 510), (idx * 3) % 8, idx));
		send_note(pack_note(0, 4, 9));
		send_note(pack_note(511, 7, 12));
		send_note(pack_note(511, 0, 1));
		wait_for_results();
	endtask

	// fast clock against the lowest tones, saturation and its boundary
	task automatic test_count_overflow();
		write_timer_config(24'd16000000, 10'd1000);
		send_note(pack_note(5, 0, 1));
		send_note(pack_note(5, 0, 11));
		send_note(pack_note(5, 0, 12));
		send_note(pack_note(5, 7, 1));
		send_note(16'hFFFF);
		write_timer_config(24'hFFFFFF, 10'd1023);
		send_note(pack_note(511, 0, 12));
		send_note(pack_note(1, 0, 1));
		wait_for_results();
	endtask

	// clock below the tone, and a zero clock
	task automatic test_slow_clock();
		write_timer_config(24'd1000, 10'd1);
		send_note(pack_note(2, 7, 12));
		send_note(pack_note(2, 7, 1));
		send_note(pack_note(2, 2, 1));
		write_timer_config(24'd0, 10'd1023);
		send_note(pack_note(7, 3, 5));
		send_note(pack_note(511, 0, 8));
		wait_for_results();
	endtask

	// receiver holds off long enough for the pipe to fill and stall the input
	task automatic test_back_pressure();
		write_timer_config(ClockHalfHzReset, MinNoteMsReset);
		sender_gaps          = 1'b0;
		receiver_stalls      = 1'b0;
		receiver_hold_cycles = 300;
		repeat (120) send_note(random_note());
		wait_for_results();
	endtask

	// short bursts with the sender draining the pipe in between
	task automatic test_sender_pause();
		sender_gaps     = 1'b1;
		receiver_stalls = 1'b1;
		repeat (4) begin
			repeat ($urandom_range(1, 30)) send_note(random_note());
			wait_for_results();
		end
	endtask

	task automatic test_random_notes();
		logic [ClockW-1:0]   clock_hz;
		logic [MinNoteW-1:0] note_ms;
		for (int unsigned p = 0; p < RandomPhases; p++) begin
			case (p)
				1:       clock_hz = 24'd1000;
				2:       clock_hz = 24'd16000000;
				5:       clock_hz = ClockW'($urandom);
				default: clock_hz = ClockW'($urandom_range(1000, 16000000));
			endcase
			case (p)
				1:       note_ms = 10'd1000;
				2:       note_ms = 10'd1;
				5:       note_ms = MinNoteW'($urandom);
				default: note_ms = MinNoteW'($urandom_range(1, 1000));
			endcase
			write_timer_config(clock_hz, note_ms);
			// phase 0 runs with no idling on either side
			sender_gaps     = (p % 2 == 1);
			receiver_stalls = (p % 3 != 0);
			repeat (NotesPerPhase) send_note(random_note());
		end
		wait_for_results();
	endtask

	initial begin : result_checker
		int unsigned   stall;
		tone_setting_t want;
		wait (arst_n === 1'b1);
		forever begin
			if (receiver_hold_cycles != 0) begin
				stall                = receiver_hold_cycles;
				receiver_hold_cycles = 0;
			end else begin
				stall = receiver_stalls ? $urandom_range(0, StallMax) : 0;
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (expected_settings.size() == 0) begin
				error_count++;
				$display("%0t: result with none pending, expected nothing actual tone_hz %0d",
					$time, tone_hz);
			end else begin
				want = expected_settings.pop_front();
				check_field("end_of_melody", want.end_of_melody, end_of_melody);
				check_field("is_rest", want.is_rest, is_rest);
				check_field("tone_hz", want.tone_hz, tone_hz);
				check_field("prescale_select", want.prescale_select, prescale_select);
				check_field("compare_value", want.compare_value, compare_value);
				check_field("range_error", want.range_error, range_error);
				check_field("tone_ms", want.tone_ms, tone_ms);
				check_field("pause_ms", want.pause_ms, pause_ms);
			end
		end
	end

	// no item moving on either side for too long means a hang
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("tb_note_to_tone_timer_setting: errors");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_notes();
		test_count_overflow();
		test_slow_clock();
		test_back_pressure();
		test_sender_pause();
		test_random_notes();
		wait_for_results();
		repeat (DrainCycles) @(posedge clk);
		if (error_count == 0) begin
			$display("tb_note_to_tone_timer_setting: clean");
		end else begin
			$display("tb_note_to_tone_timer_setting: errors");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/ntt_pkg.sv
rtl/core/ntt_decode.sv
rtl/core/ntt_divider.sv
rtl/core/ntt_prescale.sv
rtl/core/note_to_tone_timer_setting.sv
bench/tb_note_to_tone_timer_setting.sv
